// ===== hdl/tes_pkg.sv =====
// Shared widths, types and constants for the triangle element stiffness block.
// No dependencies; imported by every module under hdl/.
`default_nettype none
package tes_pkg;

    localparam int COORD_W   = 24;
    localparam int RESULT_W  = 48;
    localparam int K_W       = 32;
    localparam int TAG_W     = 16;
    localparam int N_K       = 4;
    localparam int N_KE      = 9;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int KP_W    = K_W + DIFF_W - 1;
    localparam int U_W     = KP_W + 1;
    localparam int SPLIT_W = 32;
    localparam int UH_W    = U_W - SPLIT_W;
    localparam int PL_W    = DIFF_W + SPLIT_W + 1;
    localparam int PH_W    = DIFF_W + UH_W;
    localparam int NUM_W   = DIFF_W + U_W;
    localparam int DET_W   = 2 * DIFF_W;
    localparam int D2_W    = DET_W + 1;
    localparam int N_W     = NUM_W + 2;
    localparam int TOP_W   = N_W - RESULT_W;
    localparam int R_W     = D2_W + 1;
    localparam int DIV_LAT = RESULT_W + 4;

    localparam int IN_W      = TAG_W + 6 * COORD_W;
    localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = TAG_W + N_KE * RESULT_W;
    localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8;
    localparam int OBUF_W    = OUT_TD_W + 1;

    localparam logic [RESULT_W-1:0] POS_LIM = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] NEG_LIM = {1'b1, {(RESULT_W-1){1'b0}}};

    localparam logic signed [K_W-1:0] K_ONE  = K_W'(65536);
    localparam logic signed [K_W-1:0] K_ZERO = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K_XX,
        REG_K_XY,
        REG_K_YX,
        REG_K_YY
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [K_W-1:0]     t_k;
    typedef logic signed [NUM_W-1:0]   t_num;

    typedef struct packed {
        logic             vld;
        logic             deg;
        logic [TAG_W-1:0] tag;
    } t_side;

endpackage
`default_nettype wire

// ===== hdl/tes_prep.sv =====
// Front pipeline: edge differences, determinant, tensor products and the nine numerators.
// Depends on tes_pkg. Six register stages, all advanced by i_en.
`default_nettype none
module tes_prep (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [tes_pkg::TAG_W-1:0] i_tag,
    input  tes_pkg::t_coord     i_x [3],
    input  tes_pkg::t_coord     i_y [3],
    input  tes_pkg::t_k         i_k [tes_pkg::N_K],
    output tes_pkg::t_side      o_side,
    output tes_pkg::t_num       o_num [tes_pkg::N_KE],
    output logic [tes_pkg::DET_W-1:0] o_den
);
    import tes_pkg::*;

    t_side r_side [0:5];

    logic signed [DIFF_W-1:0] n_b [3], n_c [3];
    logic signed [DIFF_W-1:0] r_b1 [3], r_c1 [3], r_b2 [3], r_c2 [3], r_b3 [3], r_c3 [3];

    logic signed [DET_W-1:0] n_dp0, n_dp1, r_dp0, r_dp1, n_det, r_det;
    logic signed [KP_W-1:0]  n_kb [3][4], r_kb [3][4];
    logic signed [U_W-1:0]   n_ux [3], n_uy [3], r_ux [3], r_uy [3];

    logic signed [PL_W-1:0]  n_pbl [N_KE], n_pcl [N_KE], r_pbl [N_KE], r_pcl [N_KE];
    logic signed [PH_W-1:0]  n_pbh [N_KE], n_pch [N_KE], r_pbh [N_KE], r_pch [N_KE];
    logic [DET_W-1:0]        n_den, r_den4, r_den5, r_den6;
    logic                    n_deg;

    logic signed [NUM_W-1:0] n_tb [N_KE], n_tc [N_KE], r_tb [N_KE], r_tc [N_KE];
    logic signed [NUM_W-1:0] n_num [N_KE], r_num [N_KE];

    // b from y differences, c from x differences (cyclic)
    always_comb begin
        n_b[0] = DIFF_W'(i_y[1]) - DIFF_W'(i_y[2]);
        n_b[1] = DIFF_W'(i_y[2]) - DIFF_W'(i_y[0]);
        n_b[2] = DIFF_W'(i_y[0]) - DIFF_W'(i_y[1]);
        n_c[0] = DIFF_W'(i_x[2]) - DIFF_W'(i_x[1]);
        n_c[1] = DIFF_W'(i_x[0]) - DIFF_W'(i_x[2]);
        n_c[2] = DIFF_W'(i_x[1]) - DIFF_W'(i_x[0]);
    end

    always_comb begin
        n_dp0 = DET_W'(r_c1[2]) * DET_W'(r_b1[1]);
        n_dp1 = DET_W'(r_c1[1]) * DET_W'(r_b1[2]);
        for (int j = 0; j < 3; j++) begin
            n_kb[j][0] = KP_W'(i_k[0]) * KP_W'(r_b1[j]);
            n_kb[j][1] = KP_W'(i_k[1]) * KP_W'(r_c1[j]);
            n_kb[j][2] = KP_W'(i_k[2]) * KP_W'(r_b1[j]);
            n_kb[j][3] = KP_W'(i_k[3]) * KP_W'(r_c1[j]);
        end
    end

    always_comb begin
        n_det = r_dp0 - r_dp1;
        for (int j = 0; j < 3; j++) begin
            n_ux[j] = U_W'(r_kb[j][0]) + U_W'(r_kb[j][1]);
            n_uy[j] = U_W'(r_kb[j][2]) + U_W'(r_kb[j][3]);
        end
    end

    // numerator products split so that no multiplier exceeds 25x33
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pbl[3*i+j] = PL_W'(r_b3[i]) * PL_W'($signed({1'b0, r_ux[j][SPLIT_W-1:0]}));
                n_pbh[3*i+j] = PH_W'(r_b3[i]) * PH_W'($signed(r_ux[j][U_W-1:SPLIT_W]));
                n_pcl[3*i+j] = PL_W'(r_c3[i]) * PL_W'($signed({1'b0, r_uy[j][SPLIT_W-1:0]}));
                n_pch[3*i+j] = PH_W'(r_c3[i]) * PH_W'($signed(r_uy[j][U_W-1:SPLIT_W]));
            end
        end
        n_den = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
        n_deg = (r_det == '0);
    end

    always_comb begin
        for (int l = 0; l < N_KE; l++) begin
            n_tb[l]  = (NUM_W'(r_pbh[l]) <<< SPLIT_W) + NUM_W'(r_pbl[l]);
            n_tc[l]  = (NUM_W'(r_pch[l]) <<< SPLIT_W) + NUM_W'(r_pcl[l]);
            n_num[l] = r_tb[l] + r_tc[l];
        end
    end

    // degenerate flag joins the side data at stage 4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) r_side[s].vld <= 1'b0;
        end else if (i_en) begin
            r_side[0].vld <= i_vld;
            r_side[0].tag <= i_tag;
            r_side[0].deg <= 1'b0;
            for (int s = 1; s < 6; s++) begin
                r_side[s].vld <= r_side[s-1].vld;
                r_side[s].tag <= r_side[s-1].tag;
                r_side[s].deg <= (s == 3) ? n_deg : r_side[s-1].deg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1 <= n_b;  r_c1 <= n_c;
            r_b2 <= r_b1; r_c2 <= r_c1;
            r_b3 <= r_b2; r_c3 <= r_c2;
            r_dp0 <= n_dp0;
            r_dp1 <= n_dp1;
            r_kb  <= n_kb;
            r_det <= n_det;
            r_ux  <= n_ux;
            r_uy  <= n_uy;
            r_pbl <= n_pbl; r_pbh <= n_pbh;
            r_pcl <= n_pcl; r_pch <= n_pch;
            r_den4 <= n_den;
            r_tb <= n_tb; r_tc <= n_tc;
            r_den5 <= r_den4;
            r_num <= n_num;
            r_den6 <= r_den5;
        end
    end

    assign o_side = r_side[5];
    assign o_num  = r_num;
    assign o_den  = r_den6;

endmodule
`default_nettype wire

// ===== hdl/tes_div.sv =====
// One lane of rounded, saturating division: round(num / den), one quotient bit per stage.
// Depends on tes_pkg. DIV_LAT register stages, advanced by i_en.
`default_nettype none
module tes_div (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  tes_pkg::t_num                i_num,
    input  wire [tes_pkg::DET_W-1:0]     i_den,
    output logic [tes_pkg::RESULT_W-1:0] o_res
);
    import tes_pkg::*;

    logic                r_neg0, r_neg1;
    logic [NUM_W-1:0]    r_mag0;
    logic [DET_W-1:0]    r_den0;
    logic [N_W-1:0]      r_n1;
    logic [D2_W-1:0]     r_d21;

    logic [D2_W-1:0]     r_rem [0:RESULT_W];
    logic [RESULT_W-1:0] r_q   [0:RESULT_W];
    logic [RESULT_W-1:0] r_nlo [0:RESULT_W];
    logic [D2_W-1:0]     r_d2  [0:RESULT_W];
    logic                r_neg [0:RESULT_W];
    logic                r_ovf [0:RESULT_W];

    logic [TOP_W-1:0]    w_top;
    logic [RESULT_W-1:0] w_q, w_mag;
    logic                w_sat;
    logic [RESULT_W-1:0] r_res;

    assign w_top = r_n1[N_W-1:RESULT_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= i_num[NUM_W-1];
            r_mag0 <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_den0 <= i_den;
            // 2|num| + den over 2*den gives the round-half-away quotient
            r_n1   <= {1'b0, r_mag0, 1'b0} + N_W'(r_den0);
            r_d21  <= {r_den0, 1'b0};
            r_neg1 <= r_neg0;
            // quotient beyond RESULT_W bits saturates outright
            r_ovf[0] <= (R_W + TOP_W)'(w_top) >= (R_W + TOP_W)'(r_d21);
            r_rem[0] <= D2_W'(w_top);
            r_q[0]   <= '0;
            r_nlo[0] <= r_n1[RESULT_W-1:0];
            r_d2[0]  <= r_d21;
            r_neg[0] <= r_neg1;
        end
    end

    for (genvar s = 0; s < RESULT_W; s++) begin : g_step
        logic [R_W-1:0] w_sh;
        logic           w_ge;
        assign w_sh = {r_rem[s], r_nlo[s][RESULT_W-1-s]};
        assign w_ge = w_sh >= R_W'(r_d2[s]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? D2_W'(w_sh - R_W'(r_d2[s])) : w_sh[D2_W-1:0];
                r_q[s+1]   <= {r_q[s][RESULT_W-2:0], w_ge};
                r_nlo[s+1] <= r_nlo[s];
                r_d2[s+1]  <= r_d2[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign w_q   = r_q[RESULT_W];
    assign w_sat = r_ovf[RESULT_W] | (r_neg[RESULT_W] ? (w_q > NEG_LIM) : (w_q > POS_LIM));
    assign w_mag = w_sat ? (r_neg[RESULT_W] ? NEG_LIM : POS_LIM) : w_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_neg[RESULT_W] ? RESULT_W'(-w_mag) : w_mag;
        end
    end

    assign o_res = r_res ^ RESULT_W'(r_rem[RESULT_W] & '0);

endmodule
`default_nettype wire

// ===== hdl/tes_obuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on tes_pkg. Space flag comes from registers only.
`default_nettype none
module tes_obuf (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  wire [tes_pkg::OBUF_W-1:0]  i_data,
    output logic                       o_space,
    output logic                       o_vld,
    input  wire                        i_ready,
    output logic [tes_pkg::OBUF_W-1:0] o_data
);
    import tes_pkg::*;

    logic [OBUF_W-1:0] r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign w_pop   = o_vld & i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ===== hdl/triangle_element_stiffness_top.sv =====
// Top level: tensor registers, stream unpacking, front pipeline, nine divider lanes, output buffer.
// Depends on tes_pkg, tes_prep, tes_div and tes_obuf.
//
//  channel   | direction | transfer when                    | carries
//  ----------+-----------+----------------------------------+-------------------------------
//  cfg       | in        | i_cfg_valid & o_cfg_ready        | register index, 32-bit value
//  s_axis    | in        | s_axis_tvalid & s_axis_tready    | tag, three vertices
//  m_axis    | out       | m_axis_tvalid & m_axis_tready    | tag, Ke row-major, degenerate
//
// One triangle per cycle sustained while the output buffer has space.
// Each triangle passes through the 6-stage front pipeline and the 48-step divider lanes (plus 4 stages).
// Synchronous active-low reset clears valids and loads the identity tensor.
// The whole pipeline holds while the two-entry output buffer is full; nothing is dropped.
`default_nettype none
module triangle_element_stiffness_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [tes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [tes_pkg::K_W-1:0]       i_cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // element_tag, vertex1_x, vertex1_y, vertex2_x, vertex2_y, vertex3_x, vertex3_y
    input  wire [tes_pkg::IN_TD_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // tag_out, ke_00, ke_01, ke_02, ke_10, ke_11, ke_12, ke_20, ke_21, ke_22
    output logic [tes_pkg::OUT_TD_W-1:0] m_axis_tdata,
    // degenerate
    output logic                         m_axis_tuser
);
    import tes_pkg::*;

    t_k    r_k [N_K];
    t_coord w_x [3], w_y [3];
    logic  w_en;
    t_side w_side;
    t_num  w_num [N_KE];
    logic [DET_W-1:0]    w_den;
    logic [RESULT_W-1:0] w_res [N_KE];
    t_side r_sd [0:DIV_LAT-1];
    logic [OBUF_W-1:0]   w_obuf_in, w_obuf_out;
    logic                w_space;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k[0] <= K_ONE;
            r_k[1] <= K_ZERO;
            r_k[2] <= K_ZERO;
            r_k[3] <= K_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_K_XX: r_k[0] <= i_cfg_data;
                REG_K_XY: r_k[1] <= i_cfg_data;
                REG_K_YX: r_k[2] <= i_cfg_data;
                REG_K_YY: r_k[3] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_x[i] = s_axis_tdata[TAG_W + (2*i)*COORD_W   +: COORD_W];
            w_y[i] = s_axis_tdata[TAG_W + (2*i+1)*COORD_W +: COORD_W];
        end
    end

    assign w_en          = w_space;
    assign s_axis_tready = w_en;

    tes_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_tag   (s_axis_tdata[TAG_W-1:0]),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_k     (r_k),
        .o_side  (w_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    for (genvar l = 0; l < N_KE; l++) begin : g_lane
        tes_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[l]),
            .i_den (w_den),
            .o_res (w_res[l])
        );
    end

    // tag, degenerate flag and valid ride alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) r_sd[s].vld <= 1'b0;
        end else if (w_en) begin
            r_sd[0] <= w_side;
            for (int s = 1; s < DIV_LAT; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    always_comb begin
        w_obuf_in = '0;
        w_obuf_in[TAG_W-1:0] = r_sd[DIV_LAT-1].tag;
        for (int l = 0; l < N_KE; l++) begin
            w_obuf_in[TAG_W + l*RESULT_W +: RESULT_W] =
                r_sd[DIV_LAT-1].deg ? '0 : w_res[l];
        end
        w_obuf_in[OBUF_W-1] = r_sd[DIV_LAT-1].deg;
    end

    tes_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en & r_sd[DIV_LAT-1].vld),
        .i_data  (w_obuf_in),
        .o_space (w_space),
        .o_vld   (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_obuf_out)
    );

    assign m_axis_tdata = w_obuf_out[OUT_TD_W-1:0];
    assign m_axis_tuser = w_obuf_out[OBUF_W-1];

endmodule
`default_nettype wire
